/* rtl/rli_pkg.sv */
// ----------------------------------------------------------------------------
// rli_pkg: shared types for the ranked list core
// Operation and status codes, plus the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rli_pkg;

  localparam int RANK_W = 7;
  localparam int ELEM_W = 8;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_PRINT  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BADPOS = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    rd_en;
    logic    wr_en;
    logic    wr_elem;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_e out_status;
    logic    out_has;
    logic    out_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_e func;
    logic  ins_bad;
    logic  acc_bad;
    logic  full;
    logic  empty;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/rli_dpath.sv */
// ----------------------------------------------------------------------------
// rli_dpath: ranked list datapath
// Element memory, element count, captured input word, rank checks and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rli_dpath #(
  parameter int CAPACITY = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rli_pkg::cmd_t              cmd_i,
  input  wire logic [$clog2(CAPACITY)-1:0] rd_addr_i,
  input  wire logic [$clog2(CAPACITY)-1:0] wr_addr_i,
  output rli_pkg::stat_t                  stat_o,
  output logic [$clog2(CAPACITY)-1:0]     rank_idx_o,
  output logic [$clog2(CAPACITY)-1:0]     last_idx_o,
  output logic [$clog2(CAPACITY)-1:0]     cnt_addr_o,
  input  wire logic [1:0]                 func_i,
  input  wire logic [rli_pkg::RANK_W-1:0] rank_i,
  input  wire logic [rli_pkg::ELEM_W-1:0] element_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [1:0]                      status_o,
  output logic                            has_element_o,
  output logic [rli_pkg::ELEM_W-1:0]      element_out_o,
  output logic                            last_o
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > rli_pkg::RANK_W) ? CW : rli_pkg::RANK_W) + 1;

  rli_pkg::func_e              func_q;
  logic [rli_pkg::RANK_W-1:0]  rank_q;
  logic [rli_pkg::ELEM_W-1:0]  elem_q;
  logic [CW-1:0]               count_q;
  logic [rli_pkg::ELEM_W-1:0]  mem_q [CAPACITY];
  logic [rli_pkg::ELEM_W-1:0]  rdata_q;
  logic [rli_pkg::ELEM_W-1:0]  wdata;

  logic                        out_valid_q;
  rli_pkg::status_e            out_status_q;
  logic                        out_has_q;
  logic [rli_pkg::ELEM_W-1:0]  out_elem_q;
  logic                        out_last_q;

  logic [CMPW-1:0]             rank_w;
  logic [CMPW-1:0]             cnt_w;

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= rli_pkg::func_e'(func_i);
      rank_q <= rank_i;
      elem_q <= element_i;
    end
  end

  // Track the number of stored elements
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CW'(1);
    end
  end

  // Element memory: one write and one registered read per cycle
  assign wdata = cmd_i.wr_elem ? elem_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Rank checks against the count
  assign rank_w = CMPW'(rank_q);
  assign cnt_w  = CMPW'(count_q);

  assign stat_o.func     = func_q;
  assign stat_o.ins_bad  = (rank_q == '0) || (rank_w > cnt_w + CMPW'(1));
  assign stat_o.acc_bad  = (rank_q == '0) || (rank_w > cnt_w);
  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign rank_idx_o = AW'(rank_w - CMPW'(1));
  assign last_idx_o = AW'(cnt_w - CMPW'(1));
  assign cnt_addr_o = AW'(cnt_w);

  // Output register: load a result word, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_has_q    <= cmd_i.out_has;
      out_elem_q   <= cmd_i.out_has ? rdata_q : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign has_element_o = out_has_q;
  assign element_out_o = out_elem_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

/* rtl/rli_ctrl.sv */
// ----------------------------------------------------------------------------
// rli_ctrl: ranked list controller
// Decodes each operation, sequences the element shifts through the memory
// and the print stream, and issues result words.
// ----------------------------------------------------------------------------
`default_nettype none

module rli_ctrl #(
  parameter int CAPACITY = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire rli_pkg::stat_t              stat_i,
  input  wire logic [$clog2(CAPACITY)-1:0] rank_idx_i,
  input  wire logic [$clog2(CAPACITY)-1:0] last_idx_i,
  input  wire logic [$clog2(CAPACITY)-1:0] cnt_addr_i,
  output rli_pkg::cmd_t                    cmd_o,
  output logic [$clog2(CAPACITY)-1:0]      rd_addr_o,
  output logic [$clog2(CAPACITY)-1:0]      wr_addr_o
);

  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_TAIL,
    S_INS_WR,
    S_GET_RD,
    S_PR_RD,
    S_PR_EM,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    src_q, src_d;
  logic [AW-1:0]    wa_q, wa_d;
  logic             pend_q, pend_d;
  rli_pkg::status_e st_q, st_d;
  logic             has_q, has_d;
  logic             up;
  logic             stop;

  assign up   = (stat_i.func == rli_pkg::FUNC_INSERT);
  assign stop = up ? (src_q == rank_idx_i) : (src_q == last_idx_i);

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    src_d     = src_q;
    wa_d      = wa_q;
    pend_d    = pend_q;
    st_d      = st_q;
    has_d     = has_q;
    cmd_o     = '0;
    rd_addr_o = src_q;
    wr_addr_o = wa_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end

      S_DECIDE: begin
        st_d   = rli_pkg::STATUS_OK;
        has_d  = 1'b0;
        pend_d = 1'b0;
        unique case (stat_i.func)
          rli_pkg::FUNC_INSERT: begin
            if (stat_i.ins_bad) begin
              st_d    = rli_pkg::STATUS_BADPOS;
              state_d = S_EMIT;
            end else if (stat_i.full) begin
              st_d    = rli_pkg::STATUS_FULL;
              state_d = S_EMIT;
            end else if (rank_idx_i == cnt_addr_i) begin
              wa_d    = rank_idx_i;
              state_d = S_INS_WR;
            end else begin
              src_d   = last_idx_i;
              wa_d    = cnt_addr_i;
              state_d = S_SHIFT;
            end
          end
          rli_pkg::FUNC_DELETE: begin
            if (stat_i.acc_bad) begin
              st_d    = rli_pkg::STATUS_BADPOS;
              state_d = S_EMIT;
            end else if (rank_idx_i == last_idx_i) begin
              cmd_o.cnt_dec = 1'b1;
              state_d       = S_EMIT;
            end else begin
              src_d   = rank_idx_i + AW'(1);
              wa_d    = rank_idx_i;
              state_d = S_SHIFT;
            end
          end
          rli_pkg::FUNC_GET: begin
            if (stat_i.acc_bad) begin
              st_d    = rli_pkg::STATUS_BADPOS;
              state_d = S_EMIT;
            end else begin
              cmd_o.rd_en = 1'b1;
              rd_addr_o   = rank_idx_i;
              state_d     = S_GET_RD;
            end
          end
          rli_pkg::FUNC_PRINT: begin
            if (stat_i.empty) begin
              state_d = S_EMIT;
            end else begin
              src_d   = '0;
              state_d = S_PR_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // Move one element a cycle: read the next source, write the last one
      S_SHIFT: begin
        cmd_o.rd_en = 1'b1;
        pend_d      = 1'b1;
        if (pend_q) begin
          cmd_o.wr_en = 1'b1;
          wa_d        = up ? (wa_q - AW'(1)) : (wa_q + AW'(1));
        end
        if (stop) begin
          state_d = S_TAIL;
        end else begin
          src_d = up ? (src_q - AW'(1)) : (src_q + AW'(1));
        end
      end

      // Write the final moved element
      S_TAIL: begin
        cmd_o.wr_en = 1'b1;
        if (up) begin
          wa_d    = wa_q - AW'(1);
          state_d = S_INS_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_EMIT;
        end
      end

      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_elem = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_EMIT;
      end

      S_GET_RD: begin
        has_d   = 1'b1;
        state_d = S_EMIT;
      end

      S_PR_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_PR_EM;
      end

      // Stream one element word, marking the last
      S_PR_EM: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = rli_pkg::STATUS_OK;
          cmd_o.out_has    = 1'b1;
          cmd_o.out_last   = (src_q == last_idx_i);
          if (src_q == last_idx_i) begin
            state_d = S_IDLE;
          end else begin
            src_d   = src_q + AW'(1);
            state_d = S_PR_RD;
          end
        end
      end

      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = st_q;
          cmd_o.out_has    = has_q;
          cmd_o.out_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and sequencing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      src_q   <= '0;
      wa_q    <= '0;
      pend_q  <= 1'b0;
      st_q    <= rli_pkg::STATUS_OK;
      has_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
      wa_q    <= wa_d;
      pend_q  <= pend_d;
      st_q    <= st_d;
      has_q   <= has_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/ranked_list_insert_delete_get_core.sv */
// ----------------------------------------------------------------------------
// ranked_list_insert_delete_get_core: ranked byte list with rank access
// Insert, delete, get and print on an ordered list addressed by rank from 1.
// ----------------------------------------------------------------------------
`default_nettype none

// Holds up to CAPACITY bytes in a single memory with one write port and one
// registered read port; the list is shifted through that port one element
// per cycle. One word is taken at a time. After acceptance, get reads the
// memory, then issues its result; a bad rank or full list answers directly.
// Insert moves later elements up one by one, then writes the new one, or
// writes it at once when appending; delete moves later elements down one by
// one, or only drops the count when the last element goes. Print reads each
// element, then loads it into the output, or gives one empty marked word on
// an empty list. A finished result sits in an output register, so the result
// side may stall without losing words; the next input word is taken once the
// current operation has issued its last result.
module ranked_list_insert_delete_get_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  func_i,
  input  wire logic [rli_pkg::RANK_W-1:0]  rank_i,
  input  wire logic [rli_pkg::ELEM_W-1:0]  element_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       status_o,
  output logic                             has_element_o,
  output logic [rli_pkg::ELEM_W-1:0]       element_out_o,
  output logic                             last_o
);

  localparam int AW = $clog2(CAPACITY);

  rli_pkg::cmd_t  cmd;
  rli_pkg::stat_t stat;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rank_idx;
  logic [AW-1:0]  last_idx;
  logic [AW-1:0]  cnt_addr;

  rli_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .rank_idx_i (rank_idx),
    .last_idx_i (last_idx),
    .cnt_addr_i (cnt_addr),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr)
  );

  rli_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .wr_addr_i     (wr_addr),
    .stat_o        (stat),
    .rank_idx_o    (rank_idx),
    .last_idx_o    (last_idx),
    .cnt_addr_o    (cnt_addr),
    .func_i        (func_i),
    .rank_i        (rank_i),
    .element_i     (element_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .has_element_o (has_element_o),
    .element_out_o (element_out_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

/* bench/ranked_list_insert_delete_get_core_tb.sv */
// ----------------------------------------------------------------------------
// ranked_list_insert_delete_get_core_tb: self-checking bench for the ranked list
// Drives insert, delete, get and print words with random idle bursts on both
// sides. A queue-based shadow of the list predicts every result word, and a
// monitor compares the words that come back field by field, in order. A short
// table of directed words covers the empty list, rank zero and ranks past the
// end. Random phases then fill the list to capacity, insert on a full list,
// stall the result side for a long stretch, drain to empty and run mixed
// traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module ranked_list_insert_delete_get_core_tb;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 250;
  localparam int DIR_ROWS    = 25;

  // One result word as the block emits it
  typedef struct {
    rli_pkg::status_e status;
    logic             has;
    logic [7:0]       elem;
    logic             last;
  } list_word_t;

  // One directed row; typed rows carry their expected single result
  typedef struct {
    rli_pkg::func_e   func;
    logic [6:0]       rank;
    logic [7:0]       elem;
    bit               typed;
    rli_pkg::status_e status;
    logic             has;
    logic [7:0]       elem_out;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] func_i;
  logic [6:0] rank_i;
  logic [7:0] element_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] status_o;
  logic       has_element_o;
  logic [7:0] element_out_o;
  logic       last_o;

  logic [7:0] list_bytes[$];
  list_word_t expected_words[$];
  list_word_t want;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         idle_on = 1'b1;
  bit         hold_rx = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{rli_pkg::FUNC_GET,    7'd1,   8'h00, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_PRINT,  7'd0,   8'h00, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_DELETE, 7'd1,   8'h00, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_INSERT, 7'd0,   8'h55, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_INSERT, 7'd2,   8'h55, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_INSERT, 7'd1,   8'hFF, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_INSERT, 7'd1,   8'h00, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_INSERT, 7'd3,   8'hA5, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_INSERT, 7'd2,   8'h5A, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_GET,    7'd1,   8'h00, 1'b0, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_GET,    7'd4,   8'h00, 1'b0, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_GET,    7'd5,   8'h00, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_GET,    7'd0,   8'h00, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_PRINT,  7'd127, 8'hFF, 1'b0, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_DELETE, 7'd0,   8'h00, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_DELETE, 7'd5,   8'h00, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_DELETE, 7'd127, 8'h00, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_INSERT, 7'd127, 8'h80, 1'b1, rli_pkg::STATUS_BADPOS, 1'b0, 8'h00},
    '{rli_pkg::FUNC_DELETE, 7'd2,   8'h00, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_DELETE, 7'd3,   8'h00, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_GET,    7'd2,   8'h00, 1'b0, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_PRINT,  7'd0,   8'h00, 1'b0, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_DELETE, 7'd1,   8'h00, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_DELETE, 7'd1,   8'h00, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00},
    '{rli_pkg::FUNC_PRINT,  7'd64,  8'h00, 1'b1, rli_pkg::STATUS_OK,     1'b0, 8'h00}
  };

  ranked_list_insert_delete_get_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .rank_i        (rank_i),
    .element_i     (element_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .has_element_o (has_element_o),
    .element_out_o (element_out_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Count and print one mismatch
  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic list_word_t make_word(rli_pkg::status_e st, logic has,
                                           logic [7:0] el, logic lst);
    list_word_t w;
    w.status = st;
    w.has    = has;
    w.elem   = el;
    w.last   = lst;
    return w;
  endfunction

  // Apply one accepted word to the shadow list and queue its result words
  function automatic void predict_list_op(rli_pkg::func_e f, logic [6:0] r,
                                          logic [7:0] e);
    int rk;
    int n;
    rk = int'(r);
    n  = list_bytes.size();
    case (f)
      rli_pkg::FUNC_INSERT: begin
        if (rk == 0 || rk > n + 1) begin
          expected_words.push_back(make_word(rli_pkg::STATUS_BADPOS, 1'b0, 8'h00, 1'b1));
        end else if (n >= CAPACITY) begin
          expected_words.push_back(make_word(rli_pkg::STATUS_FULL, 1'b0, 8'h00, 1'b1));
        end else begin
          list_bytes.insert(rk - 1, e);
          expected_words.push_back(make_word(rli_pkg::STATUS_OK, 1'b0, 8'h00, 1'b1));
        end
      end
      rli_pkg::FUNC_DELETE: begin
        if (rk == 0 || rk > n) begin
          expected_words.push_back(make_word(rli_pkg::STATUS_BADPOS, 1'b0, 8'h00, 1'b1));
        end else begin
          list_bytes.delete(rk - 1);
          expected_words.push_back(make_word(rli_pkg::STATUS_OK, 1'b0, 8'h00, 1'b1));
        end
      end
      rli_pkg::FUNC_GET: begin
        if (rk == 0 || rk > n) begin
          expected_words.push_back(make_word(rli_pkg::STATUS_BADPOS, 1'b0, 8'h00, 1'b1));
        end else begin
          expected_words.push_back(make_word(rli_pkg::STATUS_OK, 1'b1,
                                             list_bytes[rk - 1], 1'b1));
        end
      end
      default: begin
        if (n == 0) begin
          expected_words.push_back(make_word(rli_pkg::STATUS_OK, 1'b0, 8'h00, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            expected_words.push_back(make_word(rli_pkg::STATUS_OK, 1'b1, list_bytes[i],
                                               (i == n - 1)));
          end
        end
      end
    endcase
  endfunction

  // Offer one word, with an optional idle burst first; hold until accepted
  task automatic offer_word(rli_pkg::func_e f, logic [6:0] r, logic [7:0] e);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    rank_i     <= r;
    element_i  <= e;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_list_op(f, r, e);
  endtask

  // Pick an operation by weight and a rank that is mostly in range
  task automatic rand_word(int w_ins, int w_del, int w_get, int w_prt);
    int             pick;
    int             hi;
    rli_pkg::func_e f;
    logic [6:0]     r;
    pick = $urandom_range(0, w_ins + w_del + w_get + w_prt - 1);
    if (pick < w_ins) f = rli_pkg::FUNC_INSERT;
    else if (pick < w_ins + w_del) f = rli_pkg::FUNC_DELETE;
    else if (pick < w_ins + w_del + w_get) f = rli_pkg::FUNC_GET;
    else f = rli_pkg::FUNC_PRINT;
    hi = list_bytes.size() + ((f == rli_pkg::FUNC_INSERT) ? 1 : 0);
    case ($urandom_range(0, 11))
      0: r = 7'd0;
      1: r = 7'($urandom_range(0, 127));
      2: r = (hi < 127) ? 7'(hi + 1) : 7'd127;
      default: r = (hi == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, hi));
    endcase
    offer_word(f, r, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    int rx_gap;
    rx_gap = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        hold_rx = 1'b0;
        rx_gap  = LONG_HOLD;
      end
      if (rx_gap > 0) begin
        out_ready_i <= 1'b0;
        rx_gap--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        rx_gap = $urandom_range(0, 7);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_words.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (has_element_o !== want.has)
          report_mismatch($sformatf("has_element got %0b want %0b", has_element_o,
                                    want.has));
        if (element_out_o !== want.elem)
          report_mismatch($sformatf("element_out got %02h want %02h", element_out_o,
                                    want.elem));
        if (last_o !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", last_o, want.last));
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int guard;
    int settle;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    func_i      <= rli_pkg::FUNC_INSERT;
    rank_i      <= '0;
    element_i   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed rows replace the predicted word with the literal one
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_word(dir_rows[i].func, dir_rows[i].rank, dir_rows[i].elem);
      if (dir_rows[i].typed)
        expected_words[expected_words.size() - 1] =
          make_word(dir_rows[i].status, dir_rows[i].has, dir_rows[i].elem_out, 1'b1);
    end

    // Fill to capacity, then hammer the full list
    guard = 0;
    while (list_bytes.size() < CAPACITY && guard < 400) begin
      rand_word(70, 10, 15, 5);
      guard++;
    end
    repeat (12) rand_word(60, 0, 30, 10);

    // Pause the sender until every result is back
    drain_results();

    // Long result-side hold while words keep coming
    hold_rx = 1'b1;
    repeat (20) rand_word(25, 25, 40, 10);

    // Drain to empty and poke the empty list
    guard = 0;
    while (list_bytes.size() > 0 && guard < 400) begin
      rand_word(10, 60, 25, 5);
      guard++;
    end
    repeat (5) rand_word(25, 25, 25, 25);

    // Mixed traffic, then a stretch with no idling on either side
    repeat (30) rand_word(35, 30, 25, 10);
    idle_on = 1'b0;
    repeat (60) rand_word(35, 30, 25, 10);
    in_valid_i <= 1'b0;

    // Wait for the tail, then for any stray words
    settle = 0;
    while (expected_words.size() != 0 && settle < 20000) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (200) @(posedge clk_i);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived",
                                expected_words.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
